>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lsfs_pkg.sv
// ----------------------------------------------------------------------------
// lsfs_pkg
// Types and constants shared by the LED string frame serializer.
// ----------------------------------------------------------------------------
package lsfs_pkg;

    localparam int ADDR_BITS      = 6;
    localparam int BRIGHT_BITS    = 8;
    localparam int COLOUR_BITS    = 12;
    localparam int FRAME_BITS     = ADDR_BITS + BRIGHT_BITS + COLOUR_BITS;
    localparam int BIT_CNT_W      = $clog2(FRAME_BITS);
    localparam int SEGS_PER_FRAME = 1 + 2 * FRAME_BITS + 1;
    localparam int SEG_CNT_W      = $clog2(SEGS_PER_FRAME);

    localparam int LINE_W  = 2;
    localparam int REG_W   = 8;
    localparam int DUR_W   = REG_W + 1;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_HIGH = 3'd0,
        REG_ONE_LOW    = 3'd1,
        REG_ONE_HIGH   = 3'd2,
        REG_ZERO_LOW   = 3'd3,
        REG_ZERO_HIGH  = 3'd4,
        REG_ADDR_GAP   = 3'd5,
        REG_END_LOW    = 3'd6
    } cfg_idx_t;

    localparam logic [REG_W-1:0] RST_START_HIGH = 8'd10;
    localparam logic [REG_W-1:0] RST_ONE_LOW    = 8'd16;
    localparam logic [REG_W-1:0] RST_ONE_HIGH   = 8'd8;
    localparam logic [REG_W-1:0] RST_ZERO_LOW   = 8'd6;
    localparam logic [REG_W-1:0] RST_ZERO_HIGH  = 8'd18;
    localparam logic [REG_W-1:0] RST_ADDR_GAP   = 8'd6;
    localparam logic [REG_W-1:0] RST_END_LOW    = 8'd40;

    typedef struct packed {
        logic [REG_W-1:0] start_high_us;
        logic [REG_W-1:0] one_low_us;
        logic [REG_W-1:0] one_high_us;
        logic [REG_W-1:0] zero_low_us;
        logic [REG_W-1:0] zero_high_us;
        logic [REG_W-1:0] address_gap_us;
        logic [REG_W-1:0] end_low_us;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOW,
        ST_HIGH,
        ST_END
    } seq_state_t;

    typedef enum logic [1:0] {
        SEG_START,
        SEG_LOW,
        SEG_HIGH,
        SEG_END
    } seg_kind_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        seg_kind_t         kind;
        logic              bit_one;
        logic              add_gap;
        logic              level;
        logic              last;
    } seg_req_t;

endpackage

>>> hdl/led_string_frame_serializer.sv
// ----------------------------------------------------------------------------
// led_string_frame_serializer
// Turns one bulb command into 54 pin-level segments: start pulse, 26 bits of
// low and high phases (address, intensity, colour, MSB first), end gap.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  in       | in_valid / in_ready        | line_select bulb_address brightness
//           |                            | colour_value
//  out      | out_valid / out_ready      | line_index pin_level duration_us
//           |                            | last_segment
//  cfg      | cfg_write                  | cfg_index cfg_data
//
//  With no back-pressure a request is accepted, then one
//  segment per cycle goes from the sequencer through the shared duration unit.
//  A request whose line is out of range is dropped in its accept cycle.
//  Reset restores the timing registers to their defaults and empties the output.
//  A stalled output holds its segment; the sequencer waits for the slot.
// ----------------------------------------------------------------------------
module led_string_frame_serializer #(
    parameter int NUM_LINES = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lsfs_pkg::LINE_W-1:0]        line_select,
    input  logic [lsfs_pkg::ADDR_BITS-1:0]     bulb_address,
    input  logic [lsfs_pkg::BRIGHT_BITS-1:0]   brightness,
    input  logic [lsfs_pkg::COLOUR_BITS-1:0]   colour_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lsfs_pkg::LINE_W-1:0]        line_index,
    output logic                               pin_level,
    output logic [lsfs_pkg::DUR_W-1:0]         duration_us,
    output logic                               last_segment,
    input  logic                               cfg_write,
    input  logic [lsfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsfs_pkg::REG_W-1:0]         cfg_data
);
    import lsfs_pkg::*;

    cfg_regs_t          cfg_reg, cfg_next;
    seg_req_t           seg;
    logic               seg_load;
    logic               slot_free;
    logic               line_ok;
    logic [DUR_W-1:0]   duration;

    logic               out_valid_reg, out_valid_next;
    logic [LINE_W-1:0]  line_index_reg;
    logic               pin_level_reg;
    logic [DUR_W-1:0]   duration_reg;
    logic               last_reg;

    assign line_ok   = (32'(line_select) < NUM_LINES);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_START_HIGH: cfg_next.start_high_us  = cfg_data;
                REG_ONE_LOW:    cfg_next.one_low_us     = cfg_data;
                REG_ONE_HIGH:   cfg_next.one_high_us    = cfg_data;
                REG_ZERO_LOW:   cfg_next.zero_low_us    = cfg_data;
                REG_ZERO_HIGH:  cfg_next.zero_high_us   = cfg_data;
                REG_ADDR_GAP:   cfg_next.address_gap_us = cfg_data;
                REG_END_LOW:    cfg_next.end_low_us     = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_high_us  <= RST_START_HIGH;
            cfg_reg.one_low_us     <= RST_ONE_LOW;
            cfg_reg.one_high_us    <= RST_ONE_HIGH;
            cfg_reg.zero_low_us    <= RST_ZERO_LOW;
            cfg_reg.zero_high_us   <= RST_ZERO_HIGH;
            cfg_reg.address_gap_us <= RST_ADDR_GAP;
            cfg_reg.end_low_us     <= RST_END_LOW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsfs_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .line_ok     (line_ok),
        .line_select (line_select),
        .frame       ({bulb_address, brightness, colour_value}),
        .slot_free   (slot_free),
        .seg_load    (seg_load),
        .seg         (seg)
    );

    lsfs_dur u_dur (
        .seg      (seg),
        .cfg      (cfg_reg),
        .duration (duration)
    );

    // hold the segment until the request is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (seg_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (seg_load)
        begin
            line_index_reg <= seg.line;
            pin_level_reg  <= seg.level;
            duration_reg   <= duration;
            last_reg       <= seg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_index   = line_index_reg;
    assign pin_level    = pin_level_reg;
    assign duration_us  = duration_reg;
    assign last_segment = last_reg;

endmodule

>>> hdl/lsfs_dur.sv
// ----------------------------------------------------------------------------
// lsfs_dur
// Shared duration unit: selects the configured time for a segment and adds
// the address gap where requested.
// ----------------------------------------------------------------------------
module lsfs_dur (
    input  lsfs_pkg::seg_req_t            seg,
    input  lsfs_pkg::cfg_regs_t           cfg,
    output logic [lsfs_pkg::DUR_W-1:0]    duration
);
    import lsfs_pkg::*;

    logic [REG_W-1:0] base;
    logic [REG_W-1:0] gap;

    always_comb
    begin
        case (seg.kind)
            SEG_START: base = cfg.start_high_us;
            SEG_LOW:   base = seg.bit_one ? cfg.one_low_us : cfg.zero_low_us;
            SEG_HIGH:  base = seg.bit_one ? cfg.one_high_us : cfg.zero_high_us;
            SEG_END:   base = cfg.end_low_us;
            default:   base = '0;
        endcase
    end

    assign gap      = seg.add_gap ? cfg.address_gap_us : '0;
    assign duration = {1'b0, base} + {1'b0, gap};

endmodule

>>> hdl/lsfs_seq.sv
// ----------------------------------------------------------------------------
// lsfs_seq
// Frame sequencer: holds the frame, walks start, bit phases and end gap,
// one segment request per free output slot.
// ----------------------------------------------------------------------------
module lsfs_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              line_ok,
    input  logic [lsfs_pkg::LINE_W-1:0]       line_select,
    input  logic [lsfs_pkg::FRAME_BITS-1:0]   frame,
    input  logic                              slot_free,
    output logic                              seg_load,
    output lsfs_pkg::seg_req_t                seg
);
    import lsfs_pkg::*;

    seq_state_t             state_reg, state_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;
    logic [LINE_W-1:0]      line_reg, line_next;
    logic                   last_bit;

    assign last_bit = (bit_cnt_reg == BIT_CNT_W'(FRAME_BITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        line_reg  <= line_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && line_ok)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (slot_free)
                    state_next = ST_LOW;
            end
            ST_LOW:
            begin
                if (slot_free)
                    state_next = ST_HIGH;
            end
            ST_HIGH:
            begin
                if (slot_free)
                    state_next = last_bit ? ST_END : ST_LOW;
            end
            ST_END:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        seg_load    = (state_reg != ST_IDLE) && slot_free;
        seg.line    = line_reg;
        seg.bit_one = frame_reg[FRAME_BITS-1];
        seg.add_gap = 1'b0;
        seg.level   = 1'b0;
        seg.last    = 1'b0;
        case (state_reg)
            ST_START:
            begin
                seg.kind  = SEG_START;
                seg.level = 1'b1;
            end
            ST_LOW:
            begin
                seg.kind    = SEG_LOW;
                seg.add_gap = (bit_cnt_reg == BIT_CNT_W'(ADDR_BITS));
            end
            ST_HIGH:
            begin
                seg.kind  = SEG_HIGH;
                seg.level = 1'b1;
            end
            ST_END:
            begin
                seg.kind = SEG_END;
                seg.last = 1'b1;
            end
            default: seg.kind = SEG_START;
        endcase
    end

    always_comb
    begin
        frame_next   = frame_reg;
        line_next    = line_reg;
        bit_cnt_next = bit_cnt_reg;
        if (in_valid && in_ready)
        begin
            frame_next   = frame;
            line_next    = line_select;
            bit_cnt_next = '0;
        end
        else if ((state_reg == ST_HIGH) && slot_free)
        begin
            frame_next   = {frame_reg[FRAME_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
    end

endmodule

>>> hdl/lsfs_chk.sv
// ----------------------------------------------------------------------------
// lsfs_chk
// Port-level checks for the LED string frame serializer, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsfs_chk #(
    parameter int NUM_LINES = 3
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [lsfs_pkg::LINE_W-1:0]        line_select,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               pin_level,
    input logic [lsfs_pkg::DUR_W-1:0]         duration_us,
    input logic                               last_segment
);
    import lsfs_pkg::*;

    logic [SEG_CNT_W-1:0] seg_cnt_reg, seg_cnt_next;
    logic                 seg_end;
    logic                 in_busy;

    assign seg_end = (seg_cnt_reg == SEG_CNT_W'(SEGS_PER_FRAME - 1));
    assign in_busy = in_valid && in_ready && (32'(line_select) < NUM_LINES);

    always_comb
    begin
        seg_cnt_next = seg_cnt_reg;
        if (out_valid && out_ready)
            seg_cnt_next = seg_end ? '0 : seg_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_cnt_reg <= '0;
        else
            seg_cnt_reg <= seg_cnt_next;
    end

    `ASSERT_IMPL(a_last_on_end, out_valid && out_ready, last_segment == seg_end, "last flag off frame end")
    `ASSERT_IMPL(a_level_pattern, out_valid, pin_level == !seg_cnt_reg[0], "segment level out of order")
    `ASSERT_NEXT(a_busy_after_accept, in_busy, !in_ready, "ready while frame in progress")
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duration_us), "stalled segment changed")

endmodule

bind led_string_frame_serializer lsfs_chk #(.NUM_LINES(NUM_LINES)) u_lsfs_chk (.*);
